[hw/rtl/spq_pkg.sv]
// Shared types and constants of the sorted priority queue unit.
`default_nettype none

package spq_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes carried in the input tuser field.
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SCAN    = 7'b0000010,
    ST_CMP     = 7'b0000100,
    ST_PLACE   = 7'b0001000,
    ST_DEQ_RD  = 7'b0010000,
    ST_DEQ_OUT = 7'b0100000,
    ST_FAIL    = 7'b1000000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the input value, start the slot at the tail
    logic rd_slot;   // read the entry just in front of the slot
    logic rd_tail;   // read the last held entry
    logic shift;     // move the read entry one slot back, step toward the front
    logic place;     // write the new value into the slot, one more entry held
    logic pop;       // one entry fewer held
    logic out_load;  // load the result register
    logic out_ok;    // success flag of the loaded result
    logic out_rdata; // result value comes from the read data, otherwise zero
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic slot_zero;
    logic greater;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/spq_datapath.sv]
// Datapath of the sorted priority queue: entry memory, counters, result register.
`default_nettype none

module spq_datapath #(
  parameter int DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wen,
  input  wire logic [spq_pkg::CAP_W-1:0]     cfg_wdata,
  input  wire logic [spq_pkg::DATA_W-1:0]    in_value,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               out_ok,
  output logic [spq_pkg::DATA_W-1:0]         out_value,
  input  wire spq_pkg::dp_cmd_t              cmd,
  output spq_pkg::dp_status_t                status
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > spq_pkg::CAP_W) ? CW : spq_pkg::CAP_W;

  logic [spq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [spq_pkg::DATA_W-1:0] rdata;
  logic [spq_pkg::DATA_W-1:0] val;
  logic [CW-1:0]              slot;
  logic [CW-1:0]              count;
  logic [spq_pkg::CAP_W-1:0]  capacity;

  logic [CW-1:0]              slot_m1;
  logic [CW-1:0]              tail_m1;
  logic [AW-1:0]              raddr;
  logic [AW-1:0]              waddr;
  logic [spq_pkg::DATA_W-1:0] wdata;
  logic                       re;
  logic                       we;

  assign slot_m1 = slot - CW'(1);
  assign tail_m1 = count - CW'(1);
  assign raddr   = cmd.rd_tail ? tail_m1[AW-1:0] : slot_m1[AW-1:0];
  assign re      = cmd.rd_slot | cmd.rd_tail;
  assign waddr   = slot[AW-1:0];
  assign wdata   = cmd.shift ? rdata : val;
  assign we      = cmd.shift | cmd.place;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot     <= '0;
      count    <= '0;
      capacity <= spq_pkg::CAP_RESET;
    end else begin
      if (cfg_wen) begin
        capacity <= cfg_wdata;
      end
      if (cmd.capture) begin
        slot <= count;
      end else if (cmd.shift) begin
        slot <= slot_m1;
      end
      if (cmd.place) begin
        count <= count + CW'(1);
      end else if (cmd.pop) begin
        count <= tail_m1;
      end
    end
  end

  // The result register frees as soon as its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ok    <= cmd.out_ok;
      out_value <= cmd.out_rdata ? rdata : '0;
    end
  end

  // A capacity above the depth acts as the depth.
  assign status.full      = (CMPW'(count) >= CMPW'(capacity)) || (count == CW'(DEPTH));
  assign status.empty     = (count == '0);
  assign status.slot_zero = (slot == '0);
  assign status.greater   = $signed(val) > $signed(rdata);
  assign status.out_free  = !out_valid || out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> count == $past(count) - CW'(1))
    else $error("dequeue did not lower the count by one");

  a_shift_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> slot != '0)
    else $error("shift past the front of the store");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before its beat was taken");

endmodule

`default_nettype wire

[hw/rtl/spq_controller.sv]
// Controller state machine of the sorted priority queue.
`default_nettype none

module spq_controller (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_cmd,
  output logic                     in_ready,
  input  wire spq_pkg::dp_status_t status,
  output spq_pkg::dp_cmd_t         cmd
);

  spq_pkg::state_t state;
  spq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == spq_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      spq_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_cmd == spq_pkg::CMD_ENQ) begin
            state_next = status.full ? spq_pkg::ST_FAIL : spq_pkg::ST_SCAN;
          end else begin
            state_next = status.empty ? spq_pkg::ST_FAIL : spq_pkg::ST_DEQ_RD;
          end
        end
      end
      spq_pkg::ST_SCAN: begin
        if (status.slot_zero) begin
          state_next = spq_pkg::ST_PLACE;
        end else begin
          cmd.rd_slot = 1'b1;
          state_next  = spq_pkg::ST_CMP;
        end
      end
      spq_pkg::ST_CMP: begin
        // Only strictly smaller entries move back, so equals keep their place.
        if (status.greater) begin
          cmd.shift  = 1'b1;
          state_next = spq_pkg::ST_SCAN;
        end else begin
          state_next = spq_pkg::ST_PLACE;
        end
      end
      spq_pkg::ST_PLACE: begin
        if (status.out_free) begin
          cmd.place    = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_ok   = 1'b1;
          state_next   = spq_pkg::ST_IDLE;
        end
      end
      spq_pkg::ST_DEQ_RD: begin
        cmd.rd_tail = 1'b1;
        state_next  = spq_pkg::ST_DEQ_OUT;
      end
      spq_pkg::ST_DEQ_OUT: begin
        if (status.out_free) begin
          cmd.pop       = 1'b1;
          cmd.out_load  = 1'b1;
          cmd.out_ok    = 1'b1;
          cmd.out_rdata = 1'b1;
          state_next    = spq_pkg::ST_IDLE;
        end
      end
      spq_pkg::ST_FAIL: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/sorted_priority_queue_unit.sv]
// Top level of the sorted priority queue unit: controller and datapath.
//
//   channel  direction  beat                       fields
//   s_*      in         s_tvalid & s_tready        tuser: cmd, tdata: value_in
//   m_*      out        m_tvalid & m_tready        tuser: ok,  tdata: value_out
//   cfg_*    in         cfg_wen                    cfg_wdata: capacity
//
// An enqueue walks from the tail toward the front, one step per held entry smaller than
// the new value, and places the value once a larger or equal entry or the front ends the
// walk; each step is one registered read of the entry memory and one compare-and-write.
// A dequeue reads the last held entry and then loads it; a failed item loads its result.
// The next beat is taken once the result is loaded, even while it still waits; a stalled
// output holds the item's final step. Reset clears the count and sets the capacity to 16.
`default_nettype none

module sorted_priority_queue_unit #(
  parameter int DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic signed [spq_pkg::DATA_W-1:0] s_tdata,   // [31:0] value_in
  input  wire logic                              s_tuser,   // [0] cmd
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic signed [spq_pkg::DATA_W-1:0]      m_tdata,   // [31:0] value_out
  output logic                                   m_tuser,   // [0] ok
  input  wire logic                              cfg_wen,
  input  wire logic [spq_pkg::CAP_W-1:0]         cfg_wdata
);

  spq_pkg::dp_cmd_t           cmd;
  spq_pkg::dp_status_t        status;
  logic [spq_pkg::DATA_W-1:0] out_value;

  spq_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_value  (s_tdata),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_ok    (m_tuser),
    .out_value (out_value),
    .cmd       (cmd),
    .status    (status)
  );

  assign m_tdata = $signed(out_value);

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking testbench of the sorted priority queue unit.
`timescale 1ns / 1ps

module tb;
  import spq_pkg::*;

  localparam int STORE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    logic                     cmd;
    logic signed [DATA_W-1:0] value;
  } queue_op_t;

  typedef struct {
    logic                     ok;
    logic signed [DATA_W-1:0] value;
  } queue_result_t;

  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic signed [DATA_W-1:0] s_tdata;   // [31:0] value_in
  logic                     s_tuser;   // [0] cmd
  logic                     m_tvalid;
  logic                     m_tready;
  logic signed [DATA_W-1:0] m_tdata;   // [31:0] value_out
  logic                     m_tuser;   // [0] ok
  logic                     cfg_wen;
  logic [CAP_W-1:0]         cfg_wdata;

  queue_op_t     queued_ops[$];
  queue_result_t predicted_results[$];
  queue_result_t oldest_result;
  queue_op_t     next_op;

  // Mirror of the block's state, kept by the monitor alone.
  logic signed [DATA_W-1:0] mirror_store [STORE_DEPTH];
  int                       mirror_count;
  logic [CAP_W-1:0]         mirror_cap;

  logic in_fire;
  logic idle_on;
  int   in_gap;
  int   out_gap;
  int   cycle_count;
  int   error_count;
  int   result_count;
  int   beat_count;
  int   enq_count;
  int   enq_refused;
  int   deq_count;
  int   deq_empty;
  int   deepest_fill;
  int   cap_writes;

  sorted_priority_queue_unit #(
    .DEPTH(STORE_DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Applies one accepted operation to the mirror and records the result it must give.
  task automatic apply_queue_op(input logic cmd, input logic signed [DATA_W-1:0] v);
    int            cap_limit;
    int            slot;
    queue_result_t res;
    cap_limit = (int'(mirror_cap) < STORE_DEPTH) ? int'(mirror_cap) : STORE_DEPTH;
    res.ok    = 1'b0;
    res.value = '0;
    if (cmd == CMD_ENQ) begin
      enq_count++;
      if (mirror_count < cap_limit) begin
        // Equal values stay in front of the newcomer, so only strictly smaller ones move.
        slot = mirror_count;
        while (slot > 0 && v > mirror_store[slot-1]) begin
          mirror_store[slot] = mirror_store[slot-1];
          slot--;
        end
        mirror_store[slot] = v;
        mirror_count++;
        res.ok = 1'b1;
      end else begin
        enq_refused++;
      end
    end else begin
      deq_count++;
      if (mirror_count > 0) begin
        mirror_count--;
        res.value = mirror_store[mirror_count];
        res.ok    = 1'b1;
      end else begin
        deq_empty++;
      end
    end
    if (mirror_count > deepest_fill) deepest_fill = mirror_count;
    predicted_results.push_back(res);
  endtask

  task automatic add_op(input logic cmd, input logic signed [DATA_W-1:0] v);
    queue_op_t op;
    op.cmd   = cmd;
    op.value = v;
    queued_ops.push_back(op);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (queued_ops.size() != 0 || s_tvalid || predicted_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(input int cap);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= CAP_W'(cap);
    @(negedge clk);
    cfg_wen <= 1'b0;
    cap_writes++;
  endtask

  // Driver: a beat is held until taken; new beats and gaps start only when no beat is pending or after a handshake.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_fire) begin
        if (in_gap > 0) begin
          in_gap--;
          s_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 7);
          s_tvalid <= 1'b0;
        end else if (queued_ops.size() > 0) begin
          next_op = queued_ops.pop_front();
          s_tuser  <= next_op.cmd;
          s_tdata  <= next_op.value;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 7);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on every input beat and checks every output beat.
  always @(posedge clk) begin
    cycle_count++;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (cfg_wen) mirror_cap = cfg_wdata;
      if (s_tvalid && s_tready) begin
        beat_count++;
        apply_queue_op(s_tuser, s_tdata);
      end
      if (m_tvalid && m_tready) begin
        result_count++;
        if (predicted_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: result beat with nothing outstanding: ok=%0b value=%0d",
                     $realtime, m_tuser, m_tdata);
        end else begin
          oldest_result = predicted_results.pop_front();
          if (m_tuser !== oldest_result.ok || m_tdata !== oldest_result.value) begin
            error_count++;
            if (error_count <= 10)
              $display("%0t: result %0d: expected ok=%0b value=%0d, got ok=%0b value=%0d",
                       $realtime, result_count, oldest_result.ok, oldest_result.value,
                       m_tuser, m_tdata);
          end
        end
      end
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Run stopped after %0d cycles with %0d results outstanding.",
                 cycle_count, predicted_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int cap_plan[10];
    int phase;
    int n;
    int enq_pct;
    int sel;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] last_v;

    cap_plan = '{16, 1, 31, 5, 0, 17, 8, 3, 12, 16};
    clk          = 1'b0;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = CMD_ENQ;
    m_tready     = 1'b0;
    cfg_wen      = 1'b0;
    cfg_wdata    = '0;
    idle_on      = 1'b1;
    in_gap       = 0;
    out_gap      = 0;
    mirror_count = 0;
    mirror_cap   = CAP_RESET;
    cycle_count  = 0;
    error_count  = 0;
    result_count = 0;
    beat_count   = 0;
    enq_count    = 0;
    enq_refused  = 0;
    deq_count    = 0;
    deq_empty    = 0;
    deepest_fill = 0;
    cap_writes   = 0;
    last_v       = '0;
    foreach (mirror_store[i]) mirror_store[i] = '0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty queue, extreme values, duplicates, full and zero capacity.
    set_capacity(16);
    add_op(CMD_DEQ, VAL_MAX);
    add_op(CMD_ENQ, VAL_MAX);
    add_op(CMD_ENQ, VAL_MIN);
    add_op(CMD_ENQ, 32'sd0);
    add_op(CMD_ENQ, -32'sd1);
    add_op(CMD_ENQ, 32'sd1);
    add_op(CMD_ENQ, VAL_MIN);
    repeat (7) add_op(CMD_DEQ, -32'sd1);
    set_capacity(2);
    add_op(CMD_ENQ, 32'sd5);
    add_op(CMD_ENQ, 32'sd5);
    add_op(CMD_ENQ, 32'sd7);
    repeat (3) add_op(CMD_DEQ, 32'sd0);
    set_capacity(0);
    add_op(CMD_ENQ, 32'sd3);
    add_op(CMD_DEQ, 32'sd3);

    // Random phases; the queue is not drained between them, so a lowered capacity
    // often finds more entries held than it allows.
    enq_pct = 50;
    for (phase = 0; phase < 10; phase++) begin
      set_capacity(cap_plan[phase]);
      if (phase == 9) idle_on = 1'b0;
      for (n = 0; n < 125; n++) begin
        if (n % 16 == 0) enq_pct = $urandom_range(15, 85);
        sel = $urandom_range(0, 9);
        if (sel < 5)
          v = $urandom;
        else if (sel < 8)
          v = $signed($urandom_range(0, 8)) - 4;
        else if (sel == 8)
          case ($urandom_range(0, 3))
            0: v = VAL_MAX;
            1: v = VAL_MIN;
            2: v = 32'sd0;
            default: v = -32'sd1;
          endcase
        else
          v = last_v + $signed($urandom_range(0, 2)) - 1;
        last_v = v;
        add_op(($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ, v);
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Checked %0d results from %0d beats: %0d enqueues (%0d refused), %0d dequeues",
             result_count, beat_count, enq_count, enq_refused, deq_count);
    $display("(%0d on an empty queue), %0d capacity writes from 0 to 31, deepest fill %0d.",
             deq_empty, cap_writes, deepest_fill);
    if (error_count == 0 && predicted_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", error_count,
               predicted_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
